// File: rtl/lcdnw_pkg.sv
// lcdnw_pkg: types, constants and table functions for the character lcd
// nibble write sequencer. No dependencies; imported by every module of the block.
package lcdnw_pkg;

    // request opcodes
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_DATA    = 2'd1,
        OP_INIT    = 2'd2,
        OP_CURSOR  = 2'd3
    } t_opcode;

    // display constants
    localparam logic [3:0] INIT_NIBBLE = 4'h3;
    localparam logic [7:0] LONG_HOLD   = 8'd249;
    localparam logic [7:0] CURSOR_COLS = 8'd40;
    localparam logic [7:0] SET_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_OFFSET = 8'h40;

    // wake-up prefix of init: nine snapshots, index 0..8
    localparam logic [3:0] PRE_LAST   = 4'd8;
    // set-up command list of init: five bytes, index 0..4
    localparam logic [2:0] SETUP_LAST = 3'd4;

    // queued job between front and back
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] data;
    } t_job;

    // one pin snapshot
    typedef struct packed {
        logic [3:0] nibble;
        logic       reg_select;
        logic       enable;
        logic [7:0] delay_units;
        logic       last;
    } t_snap;

    // one entry of the wake-up prefix
    typedef struct packed {
        logic [3:0] nibble;
        logic       enable;
        logic [7:0] delay_units;
    } t_pre;

    // wake-up pulses on nibble 3, then one pulse on nibble 2
    function automatic t_pre init_pre(input logic [3:0] idx);
        t_pre p;
        p.nibble      = INIT_NIBBLE;
        p.enable      = 1'b0;
        p.delay_units = 8'd0;
        case (idx)
            4'd0: p.delay_units = 8'd39;
            4'd1: p.enable = 1'b1;
            4'd2: p.delay_units = 8'd4;
            4'd3: p.enable = 1'b1;
            4'd4: p.delay_units = 8'd4;
            4'd5: p.enable = 1'b1;
            4'd6: p.delay_units = 8'd1;
            4'd7: p.nibble = INIT_NIBBLE & 4'h2;
            4'd8: begin
                p.nibble = INIT_NIBBLE & 4'h2;
                p.enable = 1'b1;
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    // set-up commands: function set, display on, clear, entry mode, ddram address 0
    function automatic logic [7:0] setup_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h0E;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/lcdnw_if.sv
// lcdnw_if: valid/ready channel interfaces for the request and snapshot items.
// No dependencies.
interface lcdnw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] value;
    logic       row;

    modport source (output valid, output opcode, output value, output row, input ready);
    modport sink   (input valid, input opcode, input value, input row, output ready);
endinterface

interface lcdnw_snap_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       reg_select;
    logic       enable;
    logic [7:0] delay_units;
    logic       last;

    modport source (output valid, output nibble, output reg_select, output enable,
                    output delay_units, output last, input ready);
    modport sink   (input valid, input nibble, input reg_select, input enable,
                    input delay_units, input last, output ready);
endinterface

// File: rtl/char_lcd_nibble_write_sequencer.sv
// char_lcd_nibble_write_sequencer: top level of the 4-bit character lcd write
// sequencer. Depends on lcdnw_pkg, lcdnw_if, lcdnw_front, lcdnw_fifo, lcdnw_back.
//
// Usage:
// - i_req carries request items: opcode (command byte, data byte, init, set
//   cursor), value and row. o_snap carries pin snapshots: nibble, reg_select,
//   enable, delay_units and last, which marks the final snapshot of a request.
// - A byte or cursor request gives 5 snapshots, init gives 34; a cursor
//   column of 40 or more is accepted and gives none.
// - The first snapshot of a request passes the job queue, the sequencer state and
//   the output register before it is valid, when the sequencer is free.
// - Throughput: one snapshot per cycle while the receiver takes them; the single
//   snapshot sequencer sets this. Requests queue in a QUEUE_DEPTH entry job queue
//   and a new job starts in the cycle after the previous one's last snapshot is
//   loaded.
// - When the receiver stalls, the output register holds its snapshot, the
//   sequencer waits, and requests keep being accepted until the queue fills.
// - Synchronous reset empties the queue, idles the sequencer and drops any
//   pending snapshot.
module char_lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdnw_req_if.sink     i_req,
    lcdnw_snap_if.source  o_snap
);
    import lcdnw_pkg::*;

    logic queue_full;
    logic push;
    logic pop;
    logic job_valid;
    t_job push_job;
    t_job head_job;

    // classify requests
    lcdnw_front u_front (
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // job queue
    lcdnw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    // snapshot sequencer
    lcdnw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_snap      (o_snap)
    );

endmodule

// File: rtl/lcdnw_front.sv
// lcdnw_front: takes request items and turns them into queued jobs.
// Depends on lcdnw_pkg and lcdnw_req_if.
module lcdnw_front (
    lcdnw_req_if.sink     i_req,
    input  logic          i_queue_full,
    output logic          o_push,
    output lcdnw_pkg::t_job o_job
);
    import lcdnw_pkg::*;

    logic       keep;
    logic [7:0] cursor_cmd;

    // accept whenever the queue has room
    assign i_req.ready = !i_queue_full;

    // cursor command byte
    assign cursor_cmd = SET_DDRAM | (i_req.row ? ROW1_OFFSET : 8'h00) | i_req.value;

    // classify the request
    always_comb begin
        o_job = '0;
        keep  = 1'b1;
        case (t_opcode'(i_req.opcode))
            OP_COMMAND: o_job.data = i_req.value;
            OP_DATA: begin
                o_job.rs   = 1'b1;
                o_job.data = i_req.value;
            end
            OP_INIT: o_job.init = 1'b1;
            OP_CURSOR: begin
                o_job.data = cursor_cmd;
                keep       = (i_req.value < CURSOR_COLS);
            end
            default: keep = 1'b0;
        endcase
    end

    // out-of-range cursor items are accepted and dropped
    assign o_push = i_req.valid && i_req.ready && keep;

endmodule

// File: rtl/lcdnw_fifo.sv
// lcdnw_fifo: short job queue between the front and the back.
// Depends on lcdnw_pkg.
module lcdnw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdnw_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lcdnw_pkg::t_job o_job
);
    import lcdnw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue underflow");

    // count rises on a push without a pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("job queue count mismatch");

endmodule

// File: rtl/lcdnw_back.sv
// lcdnw_back: sequencer that expands queued jobs into pin snapshots,
// with a registered output stage. Depends on lcdnw_pkg and lcdnw_snap_if.
module lcdnw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  lcdnw_pkg::t_job i_job,
    output logic            o_pop,
    lcdnw_snap_if.source    o_snap
);
    import lcdnw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_HI_SET,
        S_HI_PULSE,
        S_LO_SET,
        S_LO_PULSE,
        S_TAIL
    } t_state;

    t_state     r_state, n_state;
    logic       r_init, n_init;
    logic       r_rs, n_rs;
    logic [7:0] r_data, n_data;
    logic [3:0] r_pre_idx, n_pre_idx;
    logic [2:0] r_byte_idx, n_byte_idx;
    logic       r_out_valid, n_out_valid;
    t_snap      r_out, n_out;

    t_snap      cur;
    t_pre       pre;
    logic [7:0] cur_byte;
    logic       job_end;
    logic       out_load;
    logic       adv;

    // current snapshot
    always_comb begin
        cur_byte = r_init ? setup_byte(r_byte_idx) : r_data;
        pre      = init_pre(r_pre_idx);
        job_end  = !r_init || (r_byte_idx == SETUP_LAST);
        cur      = '0;
        case (r_state)
            S_PRE: begin
                cur.nibble      = pre.nibble;
                cur.enable      = pre.enable;
                cur.delay_units = pre.delay_units;
            end
            S_HI_SET: begin
                cur.nibble     = cur_byte[7:4];
                cur.reg_select = r_rs;
            end
            S_HI_PULSE: begin
                cur.nibble      = cur_byte[7:4];
                cur.reg_select  = r_rs;
                cur.enable      = 1'b1;
                cur.delay_units = 8'd1;
            end
            S_LO_SET: begin
                cur.nibble     = cur_byte[3:0];
                cur.reg_select = r_rs;
            end
            S_LO_PULSE: begin
                cur.nibble      = cur_byte[3:0];
                cur.reg_select  = r_rs;
                cur.enable      = 1'b1;
                cur.delay_units = 8'd1;
            end
            S_TAIL: begin
                cur.nibble      = cur_byte[3:0];
                cur.reg_select  = r_rs;
                cur.delay_units = r_init ? LONG_HOLD : 8'd0;
                cur.last        = job_end;
            end
            default: cur = '0;
        endcase
    end

    // output stage takes a new snapshot when empty or drained
    assign out_load = !r_out_valid || o_snap.ready;
    assign adv      = (r_state != S_IDLE) && out_load;
    assign o_pop    = i_job_valid &&
                      ((r_state == S_IDLE) || (adv && r_state == S_TAIL && job_end));

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_rs       = r_rs;
        n_data     = r_data;
        n_pre_idx  = r_pre_idx;
        n_byte_idx = r_byte_idx;
        if (adv) begin
            case (r_state)
                S_PRE: begin
                    if (r_pre_idx == PRE_LAST) begin
                        n_state    = S_HI_SET;
                        n_byte_idx = '0;
                    end else begin
                        n_pre_idx = r_pre_idx + 1'b1;
                    end
                end
                S_HI_SET:   n_state = S_HI_PULSE;
                S_HI_PULSE: n_state = S_LO_SET;
                S_LO_SET:   n_state = S_LO_PULSE;
                S_LO_PULSE: n_state = S_TAIL;
                S_TAIL: begin
                    if (job_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state    = S_HI_SET;
                        n_byte_idx = r_byte_idx + 1'b1;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
        // next job starts without a gap
        if (o_pop) begin
            n_state    = i_job.init ? S_PRE : S_HI_SET;
            n_init     = i_job.init;
            n_rs       = i_job.rs;
            n_data     = i_job.data;
            n_pre_idx  = '0;
            n_byte_idx = '0;
        end
    end

    // output register next value
    always_comb begin
        n_out = r_out;
        if (adv) begin
            n_out_valid = 1'b1;
            n_out       = cur;
        end else if (o_snap.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b0;
            r_pre_idx   <= '0;
            r_byte_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_pre_idx   <= n_pre_idx;
            r_byte_idx  <= n_byte_idx;
            r_out_valid <= n_out_valid;
        end
        r_rs   <= n_rs;
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_snap.valid       = r_out_valid;
    assign o_snap.nibble      = r_out.nibble;
    assign o_snap.reg_select  = r_out.reg_select;
    assign o_snap.enable      = r_out.enable;
    assign o_snap.delay_units = r_out.delay_units;
    assign o_snap.last        = r_out.last;

    // a request never ends on a high enable
    a_last_low_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.last && r_out.enable))
        else $error("last snapshot with enable high");

    // wake-up prefix only runs for init jobs
    a_pre_is_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE) |-> (r_init && r_pre_idx <= PRE_LAST))
        else $error("wake-up prefix outside init");

    // set-up byte index stays in the command list
    a_byte_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= SETUP_LAST)
        else $error("set-up byte index out of range");

    // a job is taken only when the sequencer is free or finishing
    a_pop_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE || r_state == S_TAIL))
        else $error("job taken mid-sequence");

endmodule

// File: dv/char_lcd_nibble_write_sequencer_test.sv
// char_lcd_nibble_write_sequencer_test: self-checking testbench for the 4-bit lcd
// write sequencer; random request and snapshot traffic with idle gaps on both sides.
// Depends on lcdnw_pkg, lcdnw_if and the char_lcd_nibble_write_sequencer rtl.
module char_lcd_nibble_write_sequencer_test;
    import lcdnw_pkg::*;

    // tracks the pin snapshots each accepted request should produce
    class snap_scoreboard;
        t_snap pending[$];
        int    errors;
        int    checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function void push_pins(logic [3:0] nib, logic rs, logic en, logic [7:0] dly);
            t_snap s;
            s.nibble      = nib;
            s.reg_select  = rs;
            s.enable      = en;
            s.delay_units = dly;
            s.last        = 1'b0;
            pending.push_back(s);
        endfunction

        // high nibble then low nibble, each latched by an enable pulse
        function void push_byte(logic [7:0] b, logic rs, logic [7:0] tail);
            push_pins(b[7:4], rs, 1'b0, 8'd0);
            push_pins(b[7:4], rs, 1'b1, 8'd1);
            push_pins(b[3:0], rs, 1'b0, 8'd0);
            push_pins(b[3:0], rs, 1'b1, 8'd1);
            push_pins(b[3:0], rs, 1'b0, tail);
        endfunction

        // expected snapshots for one accepted request
        function void note_request(t_opcode op, logic [7:0] val, logic row);
            logic [7:0] wake_hold[3];
            logic [7:0] setup_cmds[5];
            int         start;
            start        = pending.size();
            wake_hold    = '{8'd4, 8'd4, 8'd1};
            setup_cmds   = '{8'h28, 8'h0E, 8'h01, 8'h06, 8'h80};
            case (op)
                OP_COMMAND: push_byte(val, 1'b0, 8'd0);
                OP_DATA:    push_byte(val, 1'b1, 8'd0);
                OP_INIT: begin
                    // wake-up: long hold on 3, three pulses, then one pulse on 2
                    push_pins(4'h3, 1'b0, 1'b0, 8'd39);
                    foreach (wake_hold[i]) begin
                        push_pins(4'h3, 1'b0, 1'b1, 8'd0);
                        push_pins(4'h3, 1'b0, 1'b0, wake_hold[i]);
                    end
                    push_pins(4'h2, 1'b0, 1'b0, 8'd0);
                    push_pins(4'h2, 1'b0, 1'b1, 8'd0);
                    foreach (setup_cmds[i])
                        push_byte(setup_cmds[i], 1'b0, 8'd249);
                end
                default: begin
                    // columns past the display width produce nothing
                    if (val < 8'd40)
                        push_byte(8'h80 | (row ? 8'h40 : 8'h00) | val, 1'b0, 8'd0);
                end
            endcase
            if (pending.size() > start)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        // compare one delivered snapshot with the oldest expected one
        function void check_snap(t_snap got);
            t_snap want;
            if (pending.size() == 0) begin
                $error("unexpected snapshot: nibble %0h rs %0b en %0b delay %0d last %0b",
                       got.nibble, got.reg_select, got.enable, got.delay_units, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.nibble != want.nibble) begin
                $error("nibble: expected %0h, got %0h", want.nibble, got.nibble);
                errors++;
            end
            if (got.reg_select != want.reg_select) begin
                $error("reg_select: expected %0b, got %0b", want.reg_select, got.reg_select);
                errors++;
            end
            if (got.enable != want.enable) begin
                $error("enable: expected %0b, got %0b", want.enable, got.enable);
                errors++;
            end
            if (got.delay_units != want.delay_units) begin
                $error("delay_units: expected %0d, got %0d", want.delay_units,
                       got.delay_units);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lcdnw_req_if  req_ch ();
    lcdnw_snap_if snap_ch ();

    char_lcd_nibble_write_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_snap  (snap_ch)
    );

    snap_scoreboard sb;
    bit             no_idle;
    int             op_seen[4];
    int             off_screen;

    // clock, period 8
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // wait length for the next item on either side
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // present one request and hold it until accepted
    task automatic send_request(input t_opcode op, input logic [7:0] val, input logic row);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        req_ch.row    <= row;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, val, row);
        op_seen[op]++;
        if (op == OP_CURSOR && val >= 8'd40)
            off_screen++;
    endtask

    // random request, weighted toward byte writes and on-screen cursor moves
    task automatic send_random_request();
        int         pick;
        t_opcode    op;
        logic [7:0] val;
        pick = $urandom_range(0, 99);
        val  = 8'($urandom());
        if (pick < 38)
            op = OP_COMMAND;
        else if (pick < 76)
            op = OP_DATA;
        else if (pick < 81)
            op = OP_INIT;
        else begin
            op = OP_CURSOR;
            if ($urandom_range(0, 4) != 0)
                val = 8'($urandom_range(0, 39));
        end
        send_request(op, val, 1'($urandom()));
    endtask

    // snapshot receiver: random stalls, checks every accepted snapshot
    initial begin
        int    stall;
        t_snap got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                @(negedge i_clk);
                snap_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            snap_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!snap_ch.valid);
            got.nibble      = snap_ch.nibble;
            got.reg_select  = snap_ch.reg_select;
            got.enable      = snap_ch.enable;
            got.delay_units = snap_ch.delay_units;
            got.last        = snap_ch.last;
            sb.check_snap(got);
        end
    end

    // stimulus and end of run
    initial begin
        sb            = new();
        no_idle       = 1'b0;
        off_screen    = 0;
        op_seen       = '{0, 0, 0, 0};
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_COMMAND;
        req_ch.value  = 8'h00;
        req_ch.row    = 1'b0;
        snap_ch.ready = 1'b0;
        i_rst_n       = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, init, cursor corners and off-screen columns
        send_request(OP_COMMAND, 8'h00, 1'b0);
        send_request(OP_COMMAND, 8'hFF, 1'b1);
        send_request(OP_DATA, 8'h00, 1'b1);
        send_request(OP_DATA, 8'hFF, 1'b0);
        send_request(OP_DATA, 8'hA5, 1'b0);
        send_request(OP_COMMAND, 8'h5A, 1'b0);
        send_request(OP_INIT, 8'h00, 1'b0);
        send_request(OP_INIT, 8'hFF, 1'b1);
        send_request(OP_CURSOR, 8'd0, 1'b0);
        send_request(OP_CURSOR, 8'd39, 1'b1);
        send_request(OP_CURSOR, 8'd39, 1'b0);
        send_request(OP_CURSOR, 8'd0, 1'b1);
        send_request(OP_CURSOR, 8'd40, 1'b0);
        send_request(OP_CURSOR, 8'hFF, 1'b1);
        send_request(OP_CURSOR, 8'd41, 1'b1);
        send_request(OP_DATA, 8'h3C, 1'b1);

        // random traffic, with some back-to-back stretches on both sides
        for (int n = 0; n < 230; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            send_random_request();
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        // drain, then let the block settle
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected snapshots never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("requests: %0d command, %0d data, %0d init, %0d cursor (%0d off-screen)",
                 op_seen[OP_COMMAND], op_seen[OP_DATA], op_seen[OP_INIT],
                 op_seen[OP_CURSOR], off_screen);
        $display("snapshots checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout
    initial begin
        #8_000_000;
        $display("timeout waiting for the block");
        $display("== FAIL ==");
        $finish;
    end

endmodule
